FILE: rtl/core/mi4_pkg.sv
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared constants and index helpers for the 4x4 matrix inverse core.
// ----------------------------------------------------------------------------
`default_nettype none

package mi4_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;

   // cofactor sign pattern (1,-1,-1,1), indexed by {row[0], col[0]}, 1 = negate
   localparam logic [3:0] COF_SIGN = 4'b0110;

   localparam logic [3:0] LAST_STEP_COF = 4'd8;
   localparam logic [3:0] LAST_STEP_DET = 4'd3;

   // n-th index (0..2) of the three indices left after dropping index e
   function automatic logic [1:0] other_idx(input logic [1:0] e, input logic [1:0] n);
      logic [1:0] v;
      v = n;
      if (n >= e) begin
         v = n + 2'd1;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mi4_mul.sv
// ----------------------------------------------------------------------------
// mi4_mul
// Bit-serial signed multiplier: word-wide x operand times wide y operand,
// one partial product added per cycle, msb first.
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_mul #(
   parameter int WORD_BITS = mi4_pkg::WORD_BITS_DEF,
   parameter int WIDE_BITS = 5 * mi4_pkg::WORD_BITS_DEF + 2 * mi4_pkg::FRAC_BITS_DEF + 6
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire [WORD_BITS-1:0]  x,
   input  wire [WIDE_BITS-1:0]  y,
   output logic                 done,
   output logic [WIDE_BITS-1:0] prod
);

   localparam int CntBits = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0] x_ff;
   logic [WIDE_BITS-1:0] y_ff;
   logic [WIDE_BITS-1:0] p_ff;
   logic [CntBits-1:0]   cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [WIDE_BITS-1:0] addend;

   // the sign bit of x carries negative weight
   always_comb begin
      addend = '0;
      if (x_ff[WORD_BITS-1]) begin
         addend = (cnt_ff == CntBits'(WORD_BITS - 1)) ? (~y_ff + 1'b1) : y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         x_ff    <= x;
         y_ff    <= y;
         p_ff    <= '0;
         cnt_ff  <= CntBits'(WORD_BITS - 1);
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         p_ff <= {p_ff[WIDE_BITS-2:0], 1'b0} + addend;
         x_ff <= {x_ff[WORD_BITS-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done = done_ff;
   assign prod = p_ff;

endmodule

`default_nettype wire

FILE: rtl/core/mi4_div.sv
// ----------------------------------------------------------------------------
// mi4_div
// Restoring divider for magnitudes: quotient limited to WORD_BITS-1 bits,
// flags saturation when the quotient would not fit.
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_div #(
   parameter int WORD_BITS = mi4_pkg::WORD_BITS_DEF,
   parameter int WIDE_BITS = 5 * mi4_pkg::WORD_BITS_DEF + 2 * mi4_pkg::FRAC_BITS_DEF + 6
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire [WIDE_BITS-1:0]  nmag,
   input  wire [WIDE_BITS-1:0]  dmag,
   output logic                 done,
   output logic                 sat,
   output logic [WORD_BITS-2:0] quot
);

   localparam int CntBits = $clog2(WORD_BITS);

   logic [WIDE_BITS-1:0] rem_ff;
   logic [WORD_BITS-2:0] lo_ff;
   logic [WORD_BITS-2:0] q_ff;
   logic [CntBits-1:0]   cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic                 sat_ff;
   logic [WIDE_BITS-1:0] trial;
   logic                 fits;

   assign trial = {rem_ff[WIDE_BITS-2:0], lo_ff[WORD_BITS-2]};
   assign fits  = nmag < (dmag << (WORD_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         sat_ff  <= 1'b0;
      end else if (start) begin
         sat_ff  <= !fits;
         done_ff <= !fits;
         busy_ff <= fits;
         rem_ff  <= nmag >> (WORD_BITS - 1);
         lo_ff   <= nmag[WORD_BITS-2:0];
         q_ff    <= '0;
         cnt_ff  <= CntBits'(WORD_BITS - 2);
      end else if (busy_ff) begin
         if (trial >= dmag) begin
            rem_ff <= trial - dmag;
            q_ff   <= {q_ff[WORD_BITS-3:0], 1'b1};
         end else begin
            rem_ff <= trial;
            q_ff   <= {q_ff[WORD_BITS-3:0], 1'b0};
         end
         lo_ff <= {lo_ff[WORD_BITS-3:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done = done_ff;
   assign sat  = sat_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

FILE: rtl/core/matrix4_inverse_core.sv
// ----------------------------------------------------------------------------
// matrix4_inverse_core
// Streaming 4x4 fixed-point matrix inverse through exact cofactors.
// ----------------------------------------------------------------------------
// Sixteen Q words enter row-major, the word with tlast starts the inverse and
// sixteen inverse words leave row-major, truncated toward zero and saturated;
// tuser flags a zero determinant (all results zero). Loading takes one cycle
// per word. After tlast the sequencer runs every product through one
// bit-serial multiplier: 144 products for the cofactors and 4 for the
// determinant, then each result goes through the restoring divider (stopped
// early when it saturates, skipped when the matrix is singular) and waits out
// any output stall. The matrix and the cofactors live in two 16-entry
// memories with registered reads.
`default_nettype none

module matrix4_inverse_core #(
   parameter int WORD_BITS = mi4_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire [((WORD_BITS + 7) / 8) * 8-1:0] req_tdata,  // element
   input  wire                                 req_tlast,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [((WORD_BITS + 7) / 8) * 8-1:0] rsp_tdata, // inv_element
   output logic                                rsp_tuser,  // singular
   output logic                                rsp_tlast
);

   localparam int WideBits = 5 * WORD_BITS + 2 * FRAC_BITS + 6;
   localparam int DataBits = ((WORD_BITS + 7) / 8) * 8;

   typedef enum logic [3:0] {
      S_LOAD, S_FX, S_FY, S_MST, S_MWAIT, S_ACC,
      S_DCHK, S_DRD, S_DST, S_DWAIT, S_OUT
   } state_type;

   typedef enum logic [0:0] { PH_COF, PH_DET } phase_type;

   state_type             state_ff;
   phase_type             phase_ff;
   logic [3:0]            load_cnt_ff;
   logic [3:0]            cof_idx_ff;
   logic [3:0]            step_ff;
   logic [3:0]            out_idx_ff;

   logic [WORD_BITS-1:0]  mat_mem [16];
   logic [WideBits-1:0]   cof_mem [16];
   logic [WORD_BITS-1:0]  mat_rd_ff;
   logic [WideBits-1:0]   cof_rd_ff;
   logic [3:0]            mat_addr;
   logic [3:0]            cof_addr;

   logic [WORD_BITS-1:0]  x_ff;
   logic [WideBits-1:0]   t0_ff, t1_ff, t2_ff, acc_ff, det_ff, dmag_ff;
   logic                  singular_ff;
   logic                  neg_ff;
   logic [WORD_BITS-1:0]  val_ff;

   logic [WORD_BITS-1:0]  rsp_elem_ff;
   logic                  rsp_valid_ff, rsp_sing_ff, rsp_last_ff;

   logic [1:0]            row, col, rs0, rs1, rs2, cs0, cs1, cs2, ca, cb, csel;
   logic [3:0]            ax, ay;
   logic [WideBits-1:0]   ysel, sum_v, cof_v, cof_abs;
   logic                  mul_start, mul_done, div_start, div_done, div_sat;
   logic [WideBits-1:0]   prod, nmag;
   logic [WORD_BITS-2:0]  quot;
   logic [WORD_BITS-1:0]  q_ext;
   logic                  req_acc;

   assign row = cof_idx_ff[3:2];
   assign col = cof_idx_ff[1:0];
   assign rs0 = mi4_pkg::other_idx(row, 2'd0);
   assign rs1 = mi4_pkg::other_idx(row, 2'd1);
   assign rs2 = mi4_pkg::other_idx(row, 2'd2);
   assign cs0 = mi4_pkg::other_idx(col, 2'd0);
   assign cs1 = mi4_pkg::other_idx(col, 2'd1);
   assign cs2 = mi4_pkg::other_idx(col, 2'd2);

   // element addresses of the current product
   always_comb begin
      ca   = (step_ff[2:1] == 2'd0) ? cs1 : cs0;
      cb   = (step_ff[2:1] == 2'd2) ? cs1 : cs2;
      csel = cs0;
      case (step_ff)
         4'd7:    csel = cs1;
         4'd8:    csel = cs2;
         default: csel = cs0;
      endcase
      if (phase_ff == PH_DET) begin
         ax = {2'd0, step_ff[1:0]};
         ay = ax;
      end else if (step_ff >= 4'd6) begin
         ax = {rs0, csel};
         ay = ax;
      end else if (!step_ff[0]) begin
         ax = {rs1, ca};
         ay = {rs2, cb};
      end else begin
         ax = {rs1, cb};
         ay = {rs2, ca};
      end
   end

   assign mat_addr = (state_ff == S_FY) ? ay : ax;
   assign cof_addr = (state_ff == S_DRD) ? {out_idx_ff[1:0], out_idx_ff[3:2]}
                                          : {2'd0, step_ff[1:0]};

   always_comb begin
      ysel = {{(WideBits - WORD_BITS){mat_rd_ff[WORD_BITS-1]}}, mat_rd_ff};
      if (phase_ff == PH_DET) begin
         ysel = cof_rd_ff;
      end else begin
         case (step_ff)
            4'd6:    ysel = t0_ff;
            4'd7:    ysel = t1_ff;
            4'd8:    ysel = t2_ff;
            default: ysel = {{(WideBits - WORD_BITS){mat_rd_ff[WORD_BITS-1]}}, mat_rd_ff};
         endcase
      end
   end

   assign sum_v   = acc_ff + prod;
   assign cof_v   = mi4_pkg::COF_SIGN[{row[0], col[0]}] ? (~sum_v + 1'b1) : sum_v;
   assign cof_abs = cof_rd_ff[WideBits-1] ? (~cof_rd_ff + 1'b1) : cof_rd_ff;
   assign nmag    = cof_abs << (2 * FRAC_BITS);
   assign q_ext   = {1'b0, quot};

   assign req_acc   = req_tvalid && req_tready;
   assign mul_start = (state_ff == S_MST);
   assign div_start = (state_ff == S_DST) && !singular_ff;

   mi4_mul #(.WORD_BITS(WORD_BITS), .WIDE_BITS(WideBits)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .x     (x_ff),
      .y     (ysel),
      .done  (mul_done),
      .prod  (prod)
   );

   mi4_div #(.WORD_BITS(WORD_BITS), .WIDE_BITS(WideBits)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .nmag  (nmag),
      .dmag  (dmag_ff),
      .done  (div_done),
      .sat   (div_sat),
      .quot  (quot)
   );

   // memories
   always_ff @(posedge clock) begin
      if (req_acc) begin
         mat_mem[load_cnt_ff] <= req_tdata[WORD_BITS-1:0];
      end
      mat_rd_ff <= mat_mem[mat_addr];
      if (state_ff == S_ACC && phase_ff == PH_COF && step_ff == mi4_pkg::LAST_STEP_COF) begin
         cof_mem[cof_idx_ff] <= cof_v;
      end
      cof_rd_ff <= cof_mem[cof_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         phase_ff     <= PH_COF;
         load_cnt_ff  <= '0;
         cof_idx_ff   <= '0;
         step_ff      <= '0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // S_OUT handles its own drain and reload
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_LOAD: begin
               if (req_acc) begin
                  if (req_tlast) begin
                     load_cnt_ff <= '0;
                     phase_ff    <= PH_COF;
                     cof_idx_ff  <= '0;
                     step_ff     <= '0;
                     state_ff    <= S_FX;
                  end else begin
                     load_cnt_ff <= load_cnt_ff + 1'b1;
                  end
               end
            end
            S_FX: state_ff <= S_FY;
            S_FY: begin
               x_ff     <= mat_rd_ff;
               state_ff <= S_MST;
            end
            S_MST: state_ff <= S_MWAIT;
            S_MWAIT: begin
               if (mul_done) begin
                  state_ff <= S_ACC;
               end
            end
            S_ACC: begin
               if (phase_ff == PH_COF) begin
                  state_ff <= S_FX;
                  case (step_ff)
                     4'd0:    t0_ff <= prod;
                     4'd1:    t0_ff <= t0_ff - prod;
                     4'd2:    t1_ff <= prod;
                     4'd3:    t1_ff <= t1_ff - prod;
                     4'd4:    t2_ff <= prod;
                     4'd5:    t2_ff <= t2_ff - prod;
                     4'd6:    acc_ff <= prod;
                     4'd7:    acc_ff <= acc_ff - prod;
                     // finished cofactor goes to cof_mem, clear for the determinant sum
                     default: acc_ff <= '0;
                  endcase
                  if (step_ff == mi4_pkg::LAST_STEP_COF) begin
                     step_ff <= '0;
                     if (cof_idx_ff == 4'd15) begin
                        phase_ff <= PH_DET;
                     end else begin
                        cof_idx_ff <= cof_idx_ff + 1'b1;
                     end
                  end else begin
                     step_ff <= step_ff + 1'b1;
                  end
               end else begin
                  acc_ff  <= sum_v;
                  step_ff <= step_ff + 1'b1;
                  if (step_ff == mi4_pkg::LAST_STEP_DET) begin
                     det_ff   <= sum_v;
                     state_ff <= S_DCHK;
                  end else begin
                     state_ff <= S_FX;
                  end
               end
            end
            S_DCHK: begin
               singular_ff <= (det_ff == '0);
               dmag_ff     <= det_ff[WideBits-1] ? (~det_ff + 1'b1) : det_ff;
               out_idx_ff  <= '0;
               state_ff    <= S_DRD;
            end
            S_DRD: state_ff <= S_DST;
            S_DST: begin
               neg_ff <= cof_rd_ff[WideBits-1] ^ det_ff[WideBits-1];
               if (singular_ff) begin
                  val_ff   <= '0;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_DWAIT;
               end
            end
            S_DWAIT: begin
               if (div_done) begin
                  if (div_sat) begin
                     val_ff <= neg_ff ? {1'b1, {(WORD_BITS - 1){1'b0}}}
                                      : {1'b0, {(WORD_BITS - 1){1'b1}}};
                  end else begin
                     val_ff <= neg_ff ? (~q_ext + 1'b1) : q_ext;
                  end
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_elem_ff  <= val_ff;
                  rsp_sing_ff  <= singular_ff;
                  rsp_last_ff  <= (out_idx_ff == 4'd15);
                  if (out_idx_ff == 4'd15) begin
                     state_ff <= S_LOAD;
                  end else begin
                     out_idx_ff <= out_idx_ff + 1'b1;
                     state_ff   <= S_DRD;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DataBits'(rsp_elem_ff);
   assign rsp_tuser  = rsp_sing_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
